// ===== src/swp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types, codes and the sine table builder for the sine wave pixel
// channel.
// ----------------------------------------------------------------------------
package swp_pkg;

  localparam int SineTableBitsDef = 10;
  localparam int LevelBitsDef     = 16;

  localparam int PhaseW = 32;
  localparam int FieldW = 16;
  localparam int ColorW = 48;
  localparam int CfgIdxW = 3;

  localparam logic [63:0] OneQ30    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAVE_CHANNEL = 3'd0,
    CFG_BASE_COLOR   = 3'd1,
    CFG_MIN_LEVEL    = 3'd2,
    CFG_MAX_LEVEL    = 3'd3,
    CFG_PHASE_RATE   = 3'd4,
    CFG_PHASE_OFFSET = 3'd5,
    CFG_IDX_STEP     = 3'd6
  } cfg_reg_e;

  // color part driven by the wave
  typedef enum logic [1:0] {
    CHAN_HUE   = 2'd0,
    CHAN_SAT   = 2'd1,
    CHAN_VALUE = 2'd2
  } chan_e;

  // sin(pi/2 * q / 2^qbits) in Q30, odd Taylor series up to x^9, clamped
  function automatic logic [63:0] quarter_sine(input logic [63:0] q, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HalfPiQ30 * q) >> qbits;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    t  = ((t * x2) >> 30) / 6;
    s  = s - t;
    t  = ((t * x2) >> 30) / 20;
    s  = s + t;
    t  = ((t * x2) >> 30) / 42;
    s  = s - t;
    t  = ((t * x2) >> 30) / 72;
    s  = s + t;
    if (s > OneQ30) s = OneQ30;
    return s;
  endfunction

  // table entry k: (1 + sin) / 2 as a level fraction, rounded half up, saturated
  function automatic logic [FieldW-1:0] wave_entry(input int k, input int tbits,
                                                   input int lbits);
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] lmax;
    int          shift;
    quad  = 64'(k) >> (tbits - 2);
    r     = 64'(k) & ((64'd1 << (tbits - 2)) - 64'd1);
    q     = quad[0] ? ((64'd1 << (tbits - 2)) - r) : r;
    s     = quarter_sine(q, tbits - 2);
    v     = quad[1] ? (OneQ30 - s) : (OneQ30 + s);
    shift = 31 - lbits;
    v     = (v + (64'd1 << (shift - 1))) >> shift;
    lmax  = (64'd1 << lbits) - 64'd1;
    if (v > lmax) v = lmax;
    return v[FieldW-1:0];
  endfunction

endpackage

// ===== src/sine_wave_pixel_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_wave_pixel_channel
// Sine wave color generator for one pixel per cycle, driven by a sine table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries one pixel request: the
// frame time and the pixel index. Output channel (out_valid_o / out_ready_i)
// returns hue, saturation and brightness for that pixel, in request order.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes one register
// per item by index; it is always ready, and writes are expected only while
// the pipeline is empty. Indexes beyond the register list are dropped.
// Six register stages: products, phase sum, table read, level product,
// reciprocal product, quotient fixup and color merge. One item is taken
// every cycle while the output is not stalled.
// Each stage holds while the one after it is full and stalled, so an output
// stall fills bubbles first and then backs up to in_ready_o; nothing is lost
// or repeated. Reset empties the pipeline and loads the register defaults;
// the sine table is a constant and needs no fill.
// ----------------------------------------------------------------------------
module sine_wave_pixel_channel #(
  parameter int SINE_TABLE_BITS = swp_pkg::SineTableBitsDef,
  parameter int LEVEL_BITS      = swp_pkg::LevelBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [swp_pkg::PhaseW-1:0]  frame_time_i,
  input  logic [swp_pkg::FieldW-1:0]  pixel_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [swp_pkg::FieldW-1:0]  hue_o,
  output logic [swp_pkg::FieldW-1:0]  saturation_o,
  output logic [swp_pkg::FieldW-1:0]  brightness_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [swp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swp_pkg::ColorW-1:0]  cfg_data_i
);

  localparam int Stages    = 6;
  localparam int TableSize = 1 << SINE_TABLE_BITS;
  localparam int FW        = swp_pkg::FieldW;
  localparam int PW        = swp_pkg::PhaseW;
  localparam int XW        = FW + LEVEL_BITS;       // level product plus rounding
  localparam int RW        = XW - LEVEL_BITS + 1;   // reciprocal and quotient width
  localparam logic [LEVEL_BITS-1:0] LevelMax = '1;
  localparam logic [LEVEL_BITS-1:0] Half     = LevelMax >> 1;
  localparam logic [63:0] RecipFull = (64'd1 << XW) / 64'(LevelMax);
  localparam logic [RW-1:0] Recip   = RecipFull[RW-1:0];

  typedef logic [LEVEL_BITS-1:0] wave_rom_t [TableSize];

  function automatic wave_rom_t build_wave_rom();
    wave_rom_t rom;
    for (int k = 0; k < TableSize; k++) begin
      rom[k] = LEVEL_BITS'(swp_pkg::wave_entry(k, SINE_TABLE_BITS, LEVEL_BITS));
    end
    return rom;
  endfunction

  localparam wave_rom_t WaveRom = build_wave_rom();

  // configuration registers
  logic [1:0]    wave_channel_q;
  logic [swp_pkg::ColorW-1:0] base_color_q;
  logic [FW-1:0] min_level_q;
  logic [FW-1:0] max_level_q;
  logic [PW-1:0] phase_rate_q;
  logic [PW-1:0] phase_offset_q;
  logic [PW-1:0] idx_phase_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_channel_q   <= swp_pkg::CHAN_VALUE;
      base_color_q     <= '0;
      min_level_q      <= '0;
      max_level_q      <= '1;
      phase_rate_q     <= '0;
      phase_offset_q   <= '0;
      idx_phase_step_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        swp_pkg::CFG_WAVE_CHANNEL: wave_channel_q   <= cfg_data_i[1:0];
        swp_pkg::CFG_BASE_COLOR:   base_color_q     <= cfg_data_i;
        swp_pkg::CFG_MIN_LEVEL:    min_level_q      <= cfg_data_i[FW-1:0];
        swp_pkg::CFG_MAX_LEVEL:    max_level_q      <= cfg_data_i[FW-1:0];
        swp_pkg::CFG_PHASE_RATE:   phase_rate_q     <= cfg_data_i[PW-1:0];
        swp_pkg::CFG_PHASE_OFFSET: phase_offset_q   <= cfg_data_i[PW-1:0];
        swp_pkg::CFG_IDX_STEP:     idx_phase_step_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] stage_rdy;

  always_comb begin
    stage_rdy[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign in_ready_o  = stage_rdy[0];
  assign out_valid_o = valid_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_rdy[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (stage_rdy[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // level span; a max below min inverts the wave
  logic          inv;
  logic [FW-1:0] span;
  assign inv  = max_level_q < min_level_q;
  assign span = inv ? (min_level_q - max_level_q) : (max_level_q - min_level_q);

  // stage 0: phase products, wrapped to one turn
  logic [PW-1:0] time_ph_q;
  logic [PW-1:0] pix_ph_q;
  logic [2*PW-1:0] time_prod;
  logic [FW+PW-1:0] pix_prod;
  assign time_prod = (2*PW)'(frame_time_i) * (2*PW)'(phase_rate_q);
  assign pix_prod  = (FW+PW)'(pixel_index_i) * (FW+PW)'(idx_phase_step_q);

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      time_ph_q <= time_prod[PW-1:0];
      pix_ph_q  <= pix_prod[PW-1:0];
    end
  end

  // stage 1: phase sum
  logic [PW-1:0] phase_q;
  always_ff @(posedge clk_i) begin
    if (stage_rdy[1]) phase_q <= time_ph_q + phase_offset_q + pix_ph_q;
  end

  // stage 2: table read
  logic [LEVEL_BITS-1:0] wave_q;
  always_ff @(posedge clk_i) begin
    if (stage_rdy[2]) wave_q <= WaveRom[phase_q[PW-1 -: SINE_TABLE_BITS]];
  end

  // stage 3: span times wave, plus half the divisor for rounding
  logic [XW-1:0] num_q;
  logic [XW-1:0] span_prod;
  assign span_prod = XW'(span) * XW'(wave_q);
  always_ff @(posedge clk_i) begin
    if (stage_rdy[3]) num_q <= span_prod + XW'(Half);
  end

  // stage 4: quotient estimate by reciprocal, low by at most one
  logic [XW-1:0]    num4_q;
  logic [RW-1:0]    qest_q;
  logic [XW+RW-1:0] recip_prod;
  assign recip_prod = (XW+RW)'(num_q) * (XW+RW)'(Recip);
  always_ff @(posedge clk_i) begin
    if (stage_rdy[4]) begin
      num4_q <= num_q;
      qest_q <= recip_prod[XW +: RW];
    end
  end

  // stage 5: fix up the quotient, apply the sign, merge into the base color
  logic [XW:0]   qest_den;
  logic [XW:0]   rem;
  logic [RW-1:0] quot;
  logic [FW-1:0] mag;
  logic [FW-1:0] level;
  logic [FW-1:0] hue_d;
  logic [FW-1:0] sat_d;
  logic [FW-1:0] val_d;
  logic [FW-1:0] hue_q;
  logic [FW-1:0] sat_q;
  logic [FW-1:0] val_q;

  always_comb begin
    qest_den = ((XW+1)'(qest_q) << LEVEL_BITS) - (XW+1)'(qest_q);
    rem      = (XW+1)'(num4_q) - qest_den;
    quot     = (rem >= (XW+1)'(LevelMax)) ? (qest_q + RW'(1)) : qest_q;
    mag      = quot[FW-1:0];
    level    = inv ? (min_level_q - mag) : (min_level_q + mag);
    hue_d    = base_color_q[3*FW-1:2*FW];
    sat_d    = base_color_q[2*FW-1:FW];
    val_d    = base_color_q[FW-1:0];
    case (wave_channel_q)
      swp_pkg::CHAN_HUE:   hue_d = level;
      swp_pkg::CHAN_SAT:   sat_d = level;
      swp_pkg::CHAN_VALUE: val_d = level;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[5]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

  // the reciprocal estimate leaves a remainder below twice the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> ((XW+2)'(rem) < ((XW+2)'(LevelMax) << 1)))
    else $error("quotient estimate off by more than one");

  // a full pipeline with a stalled output must hold off new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !out_ready_i |-> !in_ready_o)
    else $error("input taken while pipeline is full and stalled");

  // brightness stays between the two levels when the wave drives it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (wave_channel_q == swp_pkg::CHAN_VALUE) && !inv
      |-> (brightness_o >= min_level_q) && (brightness_o <= max_level_q))
    else $error("brightness outside level range");

  // same for an inverted wave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (wave_channel_q == swp_pkg::CHAN_VALUE) && inv
      |-> (brightness_o <= min_level_q) && (brightness_o >= max_level_q))
    else $error("inverted brightness outside level range");

endmodule

// ===== sim/swp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swp_checker
// Watches the register, pixel and color channels of the sine wave pixel
// channel. Keeps its own register copy and sine table, predicts the color of
// every accepted pixel and compares each accepted color in order.
// ----------------------------------------------------------------------------
module swp_checker #(
  parameter int TableBits = swp_pkg::SineTableBitsDef,
  parameter int LevelBits = swp_pkg::LevelBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [swp_pkg::PhaseW-1:0]  frame_time_i,
  input  logic [swp_pkg::FieldW-1:0]  pixel_index_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [swp_pkg::FieldW-1:0]  hue_i,
  input  logic [swp_pkg::FieldW-1:0]  saturation_i,
  input  logic [swp_pkg::FieldW-1:0]  brightness_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [swp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [swp_pkg::ColorW-1:0]  cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  localparam int          PhaseW   = swp_pkg::PhaseW;
  localparam int          FieldW   = swp_pkg::FieldW;
  localparam int          ColorW   = swp_pkg::ColorW;
  localparam int          Entries  = 1 << TableBits;
  localparam int          Quarter  = Entries / 4;
  localparam logic [63:0] LevelMax = (64'd1 << LevelBits) - 64'd1;

  typedef struct packed {
    logic [FieldW-1:0] hue;
    logic [FieldW-1:0] saturation;
    logic [FieldW-1:0] brightness;
  } hsv_t;

  logic [FieldW-1:0] sine_levels [Entries];
  hsv_t              expected_colors [$];
  hsv_t              wanted_color;
  int unsigned       mismatches;

  logic [1:0]        wave_channel;
  logic [ColorW-1:0] base_color;
  logic [FieldW-1:0] min_level;
  logic [FieldW-1:0] max_level;
  logic [PhaseW-1:0] phase_rate;
  logic [PhaseW-1:0] phase_offset;
  logic [PhaseW-1:0] idx_phase_step;

  // sin(pi/2 * q / Quarter) in Q30 from the odd series up to x^9
  function automatic logic [63:0] sin_q30(input int unsigned q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x    = (swp_pkg::HalfPiQ30 * 64'(q)) / 64'(Quarter);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + term;
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - term;
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + term;
    if (acc > swp_pkg::OneQ30) acc = swp_pkg::OneQ30;
    return acc;
  endfunction

  // (1 + sin) / 2 as a level, by quarter-wave symmetry, rounded half up
  function automatic logic [FieldW-1:0] wave_level(input int unsigned k);
    int unsigned quad;
    int unsigned r;
    int unsigned q;
    int unsigned shift;
    logic [63:0] v;
    quad  = k / Quarter;
    r     = k % Quarter;
    q     = ((quad & 1) != 0) ? (Quarter - r) : r;
    v     = ((quad & 2) != 0) ? (swp_pkg::OneQ30 - sin_q30(q))
                              : (swp_pkg::OneQ30 + sin_q30(q));
    shift = 31 - LevelBits;
    v     = (v + (64'd1 << (shift - 1))) >> shift;
    if (v > LevelMax) v = LevelMax;
    return v[FieldW-1:0];
  endfunction

  // min + (max - min) * w, magnitude rounded half away from zero
  function automatic logic [FieldW-1:0] scaled_level(input logic [63:0] w);
    logic [63:0] span;
    logic [63:0] mag;
    if (max_level >= min_level) begin
      span = 64'(max_level) - 64'(min_level);
      mag  = (span * w + LevelMax / 64'd2) / LevelMax;
      return min_level + mag[FieldW-1:0];
    end
    span = 64'(min_level) - 64'(max_level);
    mag  = (span * w + LevelMax / 64'd2) / LevelMax;
    return min_level - mag[FieldW-1:0];
  endfunction

  function automatic hsv_t predict_color(input logic [PhaseW-1:0] frame_time,
                                         input logic [FieldW-1:0] pixel_index);
    logic [PhaseW-1:0] phase;
    logic [FieldW-1:0] level;
    hsv_t              color;
    phase = frame_time * phase_rate + phase_offset
          + PhaseW'(pixel_index) * idx_phase_step;
    level = scaled_level(64'(sine_levels[phase[PhaseW-1 -: TableBits]]));
    color = base_color;
    case (wave_channel)
      swp_pkg::CHAN_HUE:   color.hue = level;
      swp_pkg::CHAN_SAT:   color.saturation = level;
      swp_pkg::CHAN_VALUE: color.brightness = level;
      default: ;
    endcase
    return color;
  endfunction

  initial begin
    for (int k = 0; k < Entries; k++) sine_levels[k] = wave_level(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_channel   = swp_pkg::CHAN_VALUE;
      base_color     = '0;
      min_level      = '0;
      max_level      = '1;
      phase_rate     = '0;
      phase_offset   = '0;
      idx_phase_step = '0;
      mismatches     = 0;
      expected_colors.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          swp_pkg::CFG_WAVE_CHANNEL: wave_channel = cfg_data_i[1:0];
          swp_pkg::CFG_BASE_COLOR:   base_color = cfg_data_i;
          swp_pkg::CFG_MIN_LEVEL:    min_level = cfg_data_i[FieldW-1:0];
          swp_pkg::CFG_MAX_LEVEL:    max_level = cfg_data_i[FieldW-1:0];
          swp_pkg::CFG_PHASE_RATE:   phase_rate = cfg_data_i[PhaseW-1:0];
          swp_pkg::CFG_PHASE_OFFSET: phase_offset = cfg_data_i[PhaseW-1:0];
          swp_pkg::CFG_IDX_STEP:     idx_phase_step = cfg_data_i[PhaseW-1:0];
          default: ;
        endcase
      end
      // check the outgoing color before queuing the incoming pixel
      if (out_valid_i && out_ready_i) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: color with none expected: got %h %h %h", $time,
                   hue_i, saturation_i, brightness_i);
          mismatches++;
        end else begin
          wanted_color = expected_colors.pop_front();
          if (hue_i !== wanted_color.hue) begin
            $display("%0t: hue mismatch: expected %h, got %h", $time,
                     wanted_color.hue, hue_i);
            mismatches++;
          end
          if (saturation_i !== wanted_color.saturation) begin
            $display("%0t: saturation mismatch: expected %h, got %h", $time,
                     wanted_color.saturation, saturation_i);
            mismatches++;
          end
          if (brightness_i !== wanted_color.brightness) begin
            $display("%0t: brightness mismatch: expected %h, got %h", $time,
                     wanted_color.brightness, brightness_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_colors.push_back(predict_color(frame_time_i, pixel_index_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_colors.size();
  end

endmodule

// ===== sim/tb_sine_wave_pixel_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_wave_pixel_channel
// Drives pixel requests and register writes into the sine wave pixel channel
// with random idle gaps on both channels, a long output hold-off and quiet
// stretches. The checker beside the block predicts and compares every color.
// ----------------------------------------------------------------------------
module tb_sine_wave_pixel_channel;

  localparam int                          PhaseW        = swp_pkg::PhaseW;
  localparam int                          FieldW        = swp_pkg::FieldW;
  localparam int                          ColorW        = swp_pkg::ColorW;
  localparam int                          CfgIdxW       = swp_pkg::CfgIdxW;
  localparam logic [swp_pkg::CfgIdxW-1:0] CfgUnmapped   = 3'd7;
  localparam logic [1:0]                  ChanNone      = 2'd3;
  localparam int                          LatencyCycles = 5;
  localparam int                          HoldCycles    = 64;
  localparam int                          PhaseItems    = 125;
  localparam int                          RandomPhases  = 6;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [PhaseW-1:0]  frame_time_i;
  logic [FieldW-1:0]  pixel_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [FieldW-1:0]  hue_o;
  logic [FieldW-1:0]  saturation_o;
  logic [FieldW-1:0]  brightness_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ColorW-1:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  bit          hold_req;
  bit          no_idle;

  sine_wave_pixel_channel u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_time_i (frame_time_i),
    .pixel_index_i(pixel_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  swp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .frame_time_i (frame_time_i),
    .pixel_index_i(pixel_index_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hue_i        (hue_o),
    .saturation_i (saturation_o),
    .brightness_i (brightness_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PhaseW-1:0] random_rate();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PhaseW'($urandom_range(1, 1 << 16));
      default: return PhaseW'($urandom);
    endcase
  endfunction

  // valid stays high on return; the caller lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [ColorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic [1:0] chan, input logic [ColorW-1:0] base,
                             input logic [FieldW-1:0] lo, input logic [FieldW-1:0] hi,
                             input logic [PhaseW-1:0] rate, input logic [PhaseW-1:0] offset,
                             input logic [PhaseW-1:0] step);
    write_reg(swp_pkg::CFG_WAVE_CHANNEL, ColorW'(chan));
    write_reg(swp_pkg::CFG_BASE_COLOR, base);
    write_reg(swp_pkg::CFG_MIN_LEVEL, ColorW'(lo));
    write_reg(swp_pkg::CFG_MAX_LEVEL, ColorW'(hi));
    write_reg(swp_pkg::CFG_PHASE_RATE, ColorW'(rate));
    write_reg(swp_pkg::CFG_PHASE_OFFSET, ColorW'(offset));
    write_reg(swp_pkg::CFG_IDX_STEP, ColorW'(step));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_setup();
    logic [FieldW-1:0] lo;
    logic [FieldW-1:0] hi;
    case ($urandom_range(0, 3))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = '1;
        hi = '0;
      end
      default: begin
        lo = FieldW'($urandom);
        hi = FieldW'($urandom);
      end
    endcase
    apply_setup(2'($urandom_range(0, 3)), ColorW'({$urandom, $urandom}), lo, hi,
                random_rate(), PhaseW'($urandom), random_rate());
  endtask

  task automatic send_pixel(input logic [PhaseW-1:0] frame_time,
                            input logic [FieldW-1:0] pixel_index);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    frame_time_i  <= frame_time;
    pixel_index_i <= pixel_index;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_pixel();
    logic [PhaseW-1:0] frame_time;
    logic [FieldW-1:0] pixel_index;
    frame_time  = ($urandom_range(0, 1) != 0) ? PhaseW'($urandom)
                                              : PhaseW'($urandom_range(0, 4095));
    pixel_index = ($urandom_range(0, 1) != 0) ? FieldW'($urandom)
                                              : FieldW'($urandom_range(0, 300));
    send_pixel(frame_time, pixel_index);
  endtask

  // drop valid and wait until every color has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        gap = idle_cycles();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    frame_time_i  = '0;
    pixel_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults right after reset
    send_pixel('0, '0);
    send_pixel('1, '1);
    settle();

    // zero phase rate, one table entry per pixel: peaks and zero crossings
    apply_setup(swp_pkg::CHAN_VALUE, 48'h1234_abcd_0000, 16'h0000, 16'hffff,
                32'h0, 32'h0, 32'h0040_0000);
    send_pixel(PhaseW'($urandom), 16'd0);
    send_pixel(PhaseW'($urandom), 16'd255);
    send_pixel(PhaseW'($urandom), 16'd256);
    send_pixel(PhaseW'($urandom), 16'd512);
    send_pixel(PhaseW'($urandom), 16'd768);
    send_pixel(PhaseW'($urandom), 16'd1023);
    settle();

    // max below min: inverted wave on hue
    apply_setup(swp_pkg::CHAN_HUE, 48'hffff_ffff_ffff, 16'hffff, 16'h0000,
                32'h0040_0000, 32'h0, 32'h0);
    send_pixel(32'd0, 16'hffff);
    send_pixel(32'd256, 16'hffff);
    send_pixel(32'd512, 16'hffff);
    send_pixel(32'd768, 16'hffff);
    settle();

    // equal levels on saturation, all phase registers at their top
    apply_setup(swp_pkg::CHAN_SAT, 48'h0, 16'h1000, 16'h1000, '1, '1, '1);
    send_pixel('1, '1);
    send_pixel(32'd1, 16'd1);
    send_pixel('0, '0);
    settle();

    // unused channel code leaves the base color; unmapped index is dropped
    write_reg(CfgUnmapped, 48'hdead_beef_cafe);
    apply_setup(ChanNone, 48'h0123_4567_89ab, 16'h0000, 16'hffff,
                32'h9e37_79b9, 32'h8000_0000, 32'h0000_1000);
    send_random_pixel();
    send_random_pixel();
    send_random_pixel();
    settle();

    // one tick per phase step unit
    apply_setup(swp_pkg::CHAN_VALUE, 48'h0, 16'h0000, 16'hffff, 32'd1, 32'h0, 32'h0);
    send_pixel('1, '0);
    send_pixel(32'h8000_0000, '0);
    settle();

    for (int phase_no = 0; phase_no < RandomPhases; phase_no++) begin
      random_setup();
      // hold the output long enough to back up the input
      if (phase_no == 1) hold_req = 1'b1;
      no_idle = (phase_no == 3);
      for (int item_no = 0; item_no < PhaseItems; item_no++) send_random_pixel();
      settle();
    end
    no_idle = 1'b0;

    repeat (LatencyCycles * 2) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sine_wave_pixel_channel.f =====
src/swp_pkg.sv
src/sine_wave_pixel_channel.sv
sim/swp_checker.sv
sim/tb_sine_wave_pixel_channel.sv
